### src/ddm_pkg.sv
// Shared constants and digit helpers for the decimal digit multiplier.
// Used by the multiply cell, the carry cell and the top level; no dependencies.
package ddm_pkg;

    // Default operand length in decimal digits
    localparam int DIGITS_DEF = 5;
    // Bits per packed BCD digit
    localparam int DIGIT_W = 4;
    // Bits of a carry-save carry digit in the multiply row (values 0..2)
    localparam int CARRY_W = 2;

    // Clamp a nibble that is not a decimal digit to nine
    function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] res;
        res = (d > 4'd9) ? 4'd9 : d;
        return res;
    endfunction

    // Split a digit product (0..81) into tens and units: {tens, units}
    // Tens by reciprocal multiply: p * 205 / 2048 is exact for p below 1024.
    function automatic logic [2*DIGIT_W-1:0] split_prod(input logic [6:0] p);
        logic [14:0]        prod;
        logic [DIGIT_W-1:0] hi;
        logic [6:0]         tens;
        logic [DIGIT_W-1:0] lo;
        prod = 15'(p) * 15'd205;
        hi   = prod[14:11];
        tens = 7'(hi) * 7'd10;
        lo   = 4'(p - tens);
        return {hi, lo};
    endfunction

endpackage

### src/ddm_mul_cell.sv
// Multiply cell: adds multiplicand times one multiplier digit into a
// carry-save decimal accumulator. Depends on ddm_pkg.
module ddm_mul_cell #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]       i_a,
    input  logic [DIGITS*ddm_pkg::DIGIT_W-1:0]         i_b,
    input  logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]       i_s,
    input  logic [2*DIGITS*ddm_pkg::CARRY_W-1:0]       i_c,
    output logic                                       o_valid,
    output logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]       o_a,
    output logic [DIGITS*ddm_pkg::DIGIT_W-1:0]         o_b,
    output logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]       o_s,
    output logic [2*DIGITS*ddm_pkg::CARRY_W-1:0]       o_c
);

    localparam int NPOS = 2 * DIGITS;
    localparam int DW   = ddm_pkg::DIGIT_W;
    localparam int CW   = ddm_pkg::CARRY_W;

    logic                 r_valid;
    logic [NPOS*DW-1:0]   r_a;
    logic [DIGITS*DW-1:0] r_b;
    logic [NPOS*DW-1:0]   r_s;
    logic [NPOS*CW-1:0]   r_c;
    logic [NPOS*DW-1:0]   n_s;
    logic [NPOS*CW-1:0]   n_c;
    logic [NPOS*DW-1:0]   w_lo;
    logic [NPOS*DW-1:0]   w_hi;

    // Form each digit product and split it into units and tens
    always_comb begin
        logic [6:0]      p;
        logic [2*DW-1:0] hl;
        for (int i = 0; i < NPOS; i++) begin
            p  = 7'(i_a[i*DW +: DW]) * 7'(i_b[DW-1:0]);
            hl = ddm_pkg::split_prod(p);
            w_lo[i*DW +: DW] = hl[DW-1:0];
            w_hi[i*DW +: DW] = hl[2*DW-1:DW];
        end
    end

    // Add per position without ripple: units here, tens and old carry from below
    always_comb begin
        logic [4:0] t;
        for (int i = 0; i < NPOS; i++) begin
            t = 5'(i_s[i*DW +: DW]) + 5'(w_lo[i*DW +: DW]);
            if (i > 0) begin
                t = t + 5'(i_c[(i-1)*CW +: CW]) + 5'(w_hi[(i-1)*DW +: DW]);
            end
            if (t >= 5'd20) begin
                n_s[i*DW +: DW] = 4'(t - 5'd20);
                n_c[i*CW +: CW] = 2'd2;
            end else if (t >= 5'd10) begin
                n_s[i*DW +: DW] = 4'(t - 5'd10);
                n_c[i*CW +: CW] = 2'd1;
            end else begin
                n_s[i*DW +: DW] = 4'(t);
                n_c[i*CW +: CW] = 2'd0;
            end
        end
    end

    // Advance valid under reset control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance payload: multiplicand moves up a digit, multiplier down a digit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= i_a << DW;
            r_b <= i_b >> DW;
            r_s <= n_s;
            r_c <= n_c;
        end
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_s     = r_s;
    assign o_c     = r_c;

endmodule

### src/ddm_res_cell.sv
// Carry cell: settles one digit of the carry-save sum and hands the carry on.
// Depends on ddm_pkg.
module ddm_res_cell #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]       i_s,
    input  logic [2*DIGITS*ddm_pkg::CARRY_W-1:0]       i_c,
    input  logic [1:0]                                 i_r,
    input  logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]       i_p,
    output logic                                       o_valid,
    output logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]       o_s,
    output logic [2*DIGITS*ddm_pkg::CARRY_W-1:0]       o_c,
    output logic [1:0]                                 o_r,
    output logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]       o_p
);

    localparam int NPOS = 2 * DIGITS;
    localparam int DW   = ddm_pkg::DIGIT_W;
    localparam int CW   = ddm_pkg::CARRY_W;

    logic               r_valid;
    logic [NPOS*DW-1:0] r_s;
    logic [NPOS*CW-1:0] r_c;
    logic [1:0]         r_r;
    logic [NPOS*DW-1:0] r_p;
    logic [DW-1:0]      n_digit;
    logic [1:0]         n_r;

    // Settle the lowest pending digit; its carry plus the stored carry go up
    always_comb begin
        logic [DW-1:0] t;
        t = i_s[DW-1:0] + 4'(i_r);
        if (t >= 4'd10) begin
            n_digit = t - 4'd10;
            n_r     = 2'd1 + i_c[CW-1:0];
        end else begin
            n_digit = t;
            n_r     = i_c[CW-1:0];
        end
    end

    // Advance valid under reset control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Shift the pending digits down and the finished digit in from the top
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= i_s >> DW;
            r_c <= i_c >> CW;
            r_r <= n_r;
            r_p <= {n_digit, i_p[NPOS*DW-1:DW]};
        end
    end

    assign o_valid = r_valid;
    assign o_s     = r_s;
    assign o_c     = r_c;
    assign o_r     = r_r;
    assign o_p     = r_p;

endmodule

### src/decimal_digit_multiplier_unit.sv
// Top level of the packed BCD multiplier: a row of multiply cells then a row
// of carry cells. Depends on ddm_pkg, ddm_mul_cell and ddm_res_cell.
//
// Multiplies two unsigned DIGITS-digit packed BCD numbers and returns the
// exact 2*DIGITS-digit packed BCD product. Nibbles above nine are taken as
// nine. The block is a pipeline of DIGITS multiply cells (one multiplier digit
// each, carry-save decimal accumulation) followed by 2*DIGITS carry cells (one
// product digit settled each), and every cell registers its outputs. A new
// transaction is accepted every cycle; the whole row holds only while a
// finished result waits at the output and the output side is not ready.
module decimal_digit_multiplier_unit #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [DIGITS*ddm_pkg::DIGIT_W-1:0]     i_multiplicand_bcd,
    input  logic [DIGITS*ddm_pkg::DIGIT_W-1:0]     i_multiplier_bcd,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [2*DIGITS*ddm_pkg::DIGIT_W-1:0]   o_product_bcd
);

    localparam int NPOS = 2 * DIGITS;
    localparam int DW   = ddm_pkg::DIGIT_W;
    localparam int CW   = ddm_pkg::CARRY_W;

    logic                 w_en;
    logic [NPOS*DW-1:0]   w_a0;
    logic [DIGITS*DW-1:0] w_b0;

    // Multiply row links
    logic                 m_valid [0:DIGITS];
    logic [NPOS*DW-1:0]   m_a     [0:DIGITS];
    logic [DIGITS*DW-1:0] m_b     [0:DIGITS];
    logic [NPOS*DW-1:0]   m_s     [0:DIGITS];
    logic [NPOS*CW-1:0]   m_c     [0:DIGITS];

    // Carry row links
    logic                 c_valid [0:NPOS];
    logic [NPOS*DW-1:0]   c_s     [0:NPOS];
    logic [NPOS*CW-1:0]   c_c     [0:NPOS];
    logic [1:0]           c_r     [0:NPOS];
    logic [NPOS*DW-1:0]   c_p     [0:NPOS];

    // Hold the whole row only when a result is waiting and not taken
    assign w_en       = !c_valid[NPOS] || i_out_ready;
    assign o_in_ready = w_en;

    // Clamp operand digits; multiplicand is widened to the product length
    always_comb begin
        w_a0 = '0;
        for (int i = 0; i < DIGITS; i++) begin
            w_a0[i*DW +: DW] = ddm_pkg::sat_digit(i_multiplicand_bcd[i*DW +: DW]);
            w_b0[i*DW +: DW] = ddm_pkg::sat_digit(i_multiplier_bcd[i*DW +: DW]);
        end
    end

    assign m_valid[0] = i_in_valid;
    assign m_a[0]     = w_a0;
    assign m_b[0]     = w_b0;
    assign m_s[0]     = '0;
    assign m_c[0]     = '0;

    // One multiply cell per multiplier digit
    for (genvar k = 0; k < DIGITS; k++) begin : g_mul
        ddm_mul_cell #(
            .DIGITS (DIGITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (m_valid[k]),
            .i_a     (m_a[k]),
            .i_b     (m_b[k]),
            .i_s     (m_s[k]),
            .i_c     (m_c[k]),
            .o_valid (m_valid[k+1]),
            .o_a     (m_a[k+1]),
            .o_b     (m_b[k+1]),
            .o_s     (m_s[k+1]),
            .o_c     (m_c[k+1])
        );
    end

    assign c_valid[0] = m_valid[DIGITS];
    assign c_s[0]     = m_s[DIGITS];
    assign c_c[0]     = m_c[DIGITS];
    assign c_r[0]     = 2'd0;
    assign c_p[0]     = '0;

    // One carry cell per product digit
    for (genvar j = 0; j < NPOS; j++) begin : g_res
        ddm_res_cell #(
            .DIGITS (DIGITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (c_valid[j]),
            .i_s     (c_s[j]),
            .i_c     (c_c[j]),
            .i_r     (c_r[j]),
            .i_p     (c_p[j]),
            .o_valid (c_valid[j+1]),
            .o_s     (c_s[j+1]),
            .o_c     (c_c[j+1]),
            .o_r     (c_r[j+1]),
            .o_p     (c_p[j+1])
        );
    end

    assign o_out_valid   = c_valid[NPOS];
    assign o_product_bcd = c_p[NPOS];

endmodule
